>>> rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

    // sample and field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int SW           = SAMPLE_WIDTH;
    localparam int POT_W        = 16;
    localparam int COEF_W       = 32;
    localparam int DT_W         = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DT   = CFG_IDX_W'(1);
    localparam logic [COEF_W-1:0]    COEF_RESET = COEF_W'(65536);
    localparam logic [DT_W-1:0]      DT_RESET   = DT_W'(16777);

    // datapath widths, derived from the field widths above but for the fixed low split
    localparam int LAP_W  = SW + 2;                 // a - 2b + c
    localparam int VS_W   = POT_W + SW;             // potential times sample
    localparam int MULC_W = LAP_W + COEF_W + 1;     // lap times unsigned coef
    localparam int SCL_W  = MULC_W - 8;             // coef*lap at F+8 fraction bits
    localparam int TERM_W = SCL_W + 1;              // vs - scaled lap
    localparam int MAG_W  = TERM_W;                 // magnitude of term
    localparam int LO_W   = 32;                     // low split of the magnitude
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + DT_W;
    localparam int PHI_W  = HI_W + DT_W;
    localparam int R_W    = PHI_W + 1;              // rounded delta magnitude
    localparam int NEW_W  = R_W + 1;                // old +/- delta before clamp

    localparam logic [PLO_W:0] RND_HALF = (PLO_W + 1)'(1) << (LO_W - 1);
    localparam logic signed [NEW_W-1:0] SAT_MAX =
        NEW_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [NEW_W-1:0] SAT_MIN = -SAT_MAX - NEW_W'(1);

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic shift;
        logic clear;
        logic out_load;
        logic out_zero;
        logic out_last;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/sfd_in_if.sv
`default_nettype none
interface sfd_in_if;
    import sfd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] re_in;
    logic signed [SW-1:0] im_in;
    logic signed [POT_W-1:0] potential;
    logic                 last_in;

    modport source (output valid, re_in, im_in, potential, last_in, input ready);
    modport sink   (input valid, re_in, im_in, potential, last_in, output ready);
endinterface
`default_nettype wire

>>> rtl/sfd_out_if.sv
`default_nettype none
interface sfd_out_if;
    import sfd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] re_out;
    logic signed [SW-1:0] im_out;
    logic                 last_out;

    modport source (output valid, re_out, im_out, last_out, input ready);
    modport sink   (input valid, re_out, im_out, last_out, output ready);
endinterface
`default_nettype wire

>>> rtl/sfd_cfg_if.sv
`default_nettype none
interface sfd_cfg_if;
    import sfd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/sfd_ctrl.sv
`default_nettype none
module sfd_ctrl import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_in,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LAP   = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_TERM  = 4'd3;
    localparam logic [3:0] ST_MAG   = 4'd4;
    localparam logic [3:0] ST_PROD  = 4'd5;
    localparam logic [3:0] ST_RND   = 4'd6;
    localparam logic [3:0] ST_APPLY = 4'd7;
    localparam logic [3:0] ST_EMIT1 = 4'd8;
    localparam logic [3:0] ST_EMITE = 4'd9;
    localparam logic [3:0] ST_TAIL  = 4'd10;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_MORE  = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_last, n_last;
    logic       r_zero, n_zero;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_last  = r_last;
        n_zero  = r_zero;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_last        = i_last_in;
                    priority case (r_phase)
                        PH_START: begin
                            n_state = i_last_in ? ST_EMITE : ST_TAIL;
                        end
                        PH_ONE: begin
                            n_state = ST_EMIT1;
                            n_zero  = 1'b1;
                        end
                        default: begin
                            // two or more points held: interior update
                            n_state = ST_LAP;
                            n_zero  = 1'b0;
                        end
                    endcase
                end
            end
            ST_LAP:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_TERM;
            ST_TERM:  n_state = ST_MAG;
            ST_MAG:   n_state = ST_PROD;
            ST_PROD:  n_state = ST_RND;
            ST_RND:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_EMIT1;
            ST_EMIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = r_zero;
                    if (r_last) begin
                        n_state = ST_EMITE;
                    end else begin
                        o_cmd.shift = 1'b1;
                        n_phase     = PH_MORE;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_EMITE: begin
                // zero end point, then back to line start
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_phase        = PH_START;
                    n_state        = ST_IDLE;
                end
            end
            ST_TAIL: begin
                o_cmd.shift = 1'b1;
                n_phase     = PH_ONE;
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_START;
            r_last  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_last  <= n_last;
            r_zero  <= n_zero;
        end
    end

    a_apply_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |=> (r_state == ST_EMIT1))
        else $error("computed result not followed by its emit");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> (r_phase == PH_START && r_state == ST_IDLE))
        else $error("line end did not return to line start");

    a_shift_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift |=> (r_phase != PH_START))
        else $error("window shifted but phase still at line start");

endmodule
`default_nettype wire

>>> rtl/sfd_datapath.sv
`default_nettype none
module sfd_datapath import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sfd_in_if.sink     i_pt,
    sfd_out_if.source  o_pt,
    sfd_cfg_if.sink    i_cfg,
    input  t_cmd i_cmd,
    output t_sts o_sts
);

    // lane 0 updates the imaginary part, lane 1 the real part
    localparam logic [1:0] LANE_SUB = 2'b10;

    logic [COEF_W-1:0] r_coef;
    logic [DT_W-1:0]   r_dt;

    logic signed [SW-1:0]    r_cur_re, r_cur_im;
    logic signed [POT_W-1:0] r_cur_pot;
    logic signed [SW-1:0]    r_re_w0, r_re_w1, r_im_w0, r_im_w1;
    logic signed [POT_W-1:0] r_pot;

    logic signed [LAP_W-1:0]  r_lap  [2];
    logic signed [VS_W-1:0]   r_vs   [2];
    logic signed [SCL_W-1:0]  r_scl  [2];
    logic signed [TERM_W-1:0] r_term [2];
    logic [MAG_W-1:0]         r_mag  [2];
    logic [1:0]               r_neg;
    logic [PLO_W-1:0]         r_plo  [2];
    logic [PHI_W-1:0]         r_phi  [2];
    logic [R_W-1:0]           r_rnd  [2];
    logic signed [SW-1:0]     r_new  [2];

    logic signed [LAP_W-1:0]  n_lap  [2];
    logic signed [VS_W-1:0]   n_vs   [2];
    logic signed [SCL_W-1:0]  n_scl  [2];
    logic signed [TERM_W-1:0] n_term [2];
    logic [MAG_W-1:0]         n_mag  [2];
    logic [1:0]               n_neg;
    logic [PLO_W-1:0]         n_plo  [2];
    logic [PHI_W-1:0]         n_phi  [2];
    logic [R_W-1:0]           n_rnd  [2];
    logic signed [SW-1:0]     n_new  [2];

    logic signed [SW-1:0]     s_w0 [2];
    logic signed [SW-1:0]     s_w1 [2];
    logic signed [SW-1:0]     s_cur [2];
    logic signed [SW-1:0]     s_base [2];
    logic signed [MULC_W-1:0] t_prod [2];
    logic [TERM_W-1:0]        t_u [2];
    logic [PLO_W:0]           t_sum [2];
    logic signed [NEW_W-1:0]  t_b [2];
    logic signed [NEW_W-1:0]  t_d [2];
    logic signed [NEW_W-1:0]  t_new [2];

    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_re, r_out_im;
    logic                 r_out_last;

    assign o_sts.out_free = !r_out_valid || o_pt.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
            r_dt   <= DT_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_COEF) begin
                r_coef <= i_cfg.data[COEF_W-1:0];
            end else if (i_cfg.index == CFG_DT) begin
                r_dt <= i_cfg.data[DT_W-1:0];
            end
        end
    end

    // captured request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_re  <= i_pt.re_in;
            r_cur_im  <= i_pt.im_in;
            r_cur_pot <= i_pt.potential;
        end
    end

    // three point window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_re_w0 <= '0;
            r_re_w1 <= '0;
            r_im_w0 <= '0;
            r_im_w1 <= '0;
            r_pot   <= '0;
        end else if (i_cmd.shift) begin
            r_re_w0 <= r_re_w1;
            r_re_w1 <= r_cur_re;
            r_im_w0 <= r_im_w1;
            r_im_w1 <= r_cur_im;
            r_pot   <= r_cur_pot;
        end
    end

    // lane sources
    always_comb begin
        s_w0[0]   = r_re_w0;
        s_w1[0]   = r_re_w1;
        s_cur[0]  = r_cur_re;
        s_base[0] = r_im_w1;
        s_w0[1]   = r_im_w0;
        s_w1[1]   = r_im_w1;
        s_cur[1]  = r_cur_im;
        s_base[1] = r_re_w1;
    end

    // per lane stage logic
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // second difference and potential term
            n_lap[l] = {{2{s_w0[l][SW-1]}}, s_w0[l]}
                     - {s_w1[l][SW-1], s_w1[l], 1'b0}
                     + {{2{s_cur[l][SW-1]}}, s_cur[l]};
            n_vs[l]  = r_pot * s_w1[l];

            // coef times lap, floor at F+8 fraction bits
            t_prod[l] = r_lap[l] * $signed({1'b0, r_coef});
            n_scl[l]  = t_prod[l][MULC_W-1:8];

            n_term[l] = TERM_W'(r_vs[l]) - TERM_W'(r_scl[l]);

            // sign and magnitude
            t_u[l]   = r_term[l];
            n_neg[l] = t_u[l][TERM_W-1];
            n_mag[l] = t_u[l][TERM_W-1] ? (~t_u[l] + 1'b1) : t_u[l];

            // magnitude times dt in two partial products
            n_plo[l] = r_mag[l][LO_W-1:0] * r_dt;
            n_phi[l] = r_mag[l][MAG_W-1:LO_W] * r_dt;

            // round half up on the magnitude
            t_sum[l] = {1'b0, r_plo[l]} + RND_HALF;
            n_rnd[l] = R_W'(r_phi[l]) + R_W'(t_sum[l][PLO_W:LO_W]);

            // apply delta and clamp
            t_b[l] = NEW_W'(s_base[l]);
            t_d[l] = $signed({{(NEW_W - R_W){1'b0}}, r_rnd[l]});
            if (r_neg[l] ^ LANE_SUB[l]) begin
                t_new[l] = t_b[l] - t_d[l];
            end else begin
                t_new[l] = t_b[l] + t_d[l];
            end
            if (t_new[l] > SAT_MAX) begin
                n_new[l] = SAT_MAX[SW-1:0];
            end else if (t_new[l] < SAT_MIN) begin
                n_new[l] = SAT_MIN[SW-1:0];
            end else begin
                n_new[l] = t_new[l][SW-1:0];
            end
        end
    end

    // arithmetic stages, sources hold while the controller steps through
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        for (int l = 0; l < 2; l++) begin
            r_lap[l]  <= n_lap[l];
            r_vs[l]   <= n_vs[l];
            r_scl[l]  <= n_scl[l];
            r_term[l] <= n_term[l];
            r_mag[l]  <= n_mag[l];
            r_plo[l]  <= n_plo[l];
            r_phi[l]  <= n_phi[l];
            r_rnd[l]  <= n_rnd[l];
            r_new[l]  <= n_new[l];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_re   <= i_cmd.out_zero ? '0 : r_new[1];
            r_out_im   <= i_cmd.out_zero ? '0 : r_new[0];
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_pt.valid    = r_out_valid;
    assign o_pt.re_out   = r_out_re;
    assign o_pt.im_out   = r_out_im;
    assign o_pt.last_out = r_out_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_pt.ready))
        else $error("result loaded over one not yet taken");

    a_clear_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_pot == '0 && r_re_w1 == '0 && r_im_w1 == '0 && r_re_w0 == '0))
        else $error("window not cleared at line end");

endmodule
`default_nettype wire

>>> rtl/schrodinger_fd_step_1d.sv
`default_nettype none
// One explicit time step of the 1D Schrodinger equation over a streamed line.
// i_pt takes one grid point per request (re_in, im_in, potential, last_in);
// o_pt gives one updated point per request (re_out, im_out, last_out).
// i_cfg writes half_inv_dx_sq (index 0) and time_step (index 1); it is always
// ready; write it only while no point is in flight; the block does not check.
// A point is handled one at a time by a controller stepping a datapath:
//   first point of a line: taken into the window, no result
//   second point: zero result for the first point
//   later points: accept, 7 arithmetic stages, emit
//   last point: an end state then emits the zero end point, last_out set,
//   except a line of one point, which goes straight to that end state
// The arithmetic stages are lap, coef multiply, term, magnitude, dt partial
// products, rounding and clamp.
// An interior result reaches o_pt through the arithmetic stages, the emit state
// and the output register; the zero result for the first point skips the stages.
// The output register lets the next request be accepted while a result waits;
// a stalled receiver holds the controller in its emit state until it frees.
// Synchronous reset restores both configuration values, clears the window
// and returns to line start.
module schrodinger_fd_step_1d import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sfd_in_if.sink    i_pt,
    sfd_out_if.source o_pt,
    sfd_cfg_if.sink   i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_pt.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_last_in  (i_pt.last_in),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sfd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .o_pt    (o_pt),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
`default_nettype wire
